// ===== hw/rtl/ptmw_pkg.sv =====
// Shared types, constants and helpers for the page table map walker.
`timescale 1ns / 1ps
package ptmw_pkg;

  // Table pool and data frame limits.
  localparam int POOL_PAGES = 128;
  localparam int DATA_PAGES = 65536;

  // Field and table geometry.
  localparam int FRAME_W    = 40;
  localparam int VPAGE_W    = 36;
  localparam int ENT_W      = 64;
  localparam int IDX_W      = 9;
  localparam int FRAME_LSB  = 12;
  localparam int LARGE_W    = 21 - FRAME_LSB;
  localparam int PAGE_W     = $clog2(POOL_PAGES);
  localparam int CNT_W      = $clog2(POOL_PAGES + 1);
  localparam int DCNT_W     = $clog2(DATA_PAGES + 1);
  localparam int ADDR_W     = PAGE_W + IDX_W;
  localparam int STATUS_W   = 3;
  localparam int ADDED_W    = 2;

  // Entry flag bits.
  localparam int BIT_P  = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_PS = 7;

  // Level codes (level number minus one).
  localparam logic [1:0] LVL_1 = 2'd0;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_4 = 2'd3;

  // Configuration port.
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_BIT = 3;
  localparam logic REG_POOL_FRAME = 1'b0;
  localparam logic REG_DATA_BASE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_MAPPED       = 3'd0,
    STAT_ALREADY      = 3'd1,
    STAT_INSIDE_LARGE = 3'd2,
    STAT_POOL_FULL    = 3'd3,
    STAT_DATA_FULL    = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_PREP,
    S_ALLOC,
    S_LINK,
    S_LEAF,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    rd;
    logic    descend;
    logic    mark_k;
    logic    prep;
    logic    alloc;
    logic    link;
    logic    leaf_wr;
    logic    res_load;
    status_t res_code;
    logic    out_load;
  } ptmw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic at_leaf;
    logic ent_zero;
    logic inside_large;
    logic follow_ok;
    logic has_k;
    logic pool_full;
    logic need_auto;
    logic data_full;
    logic link_more;
  } ptmw_stat_t;

  // Builds a present, writable entry pointing at a frame.
  function automatic logic [ENT_W-1:0] make_entry(input logic [FRAME_W-1:0] frame);
    logic [ENT_W-1:0] e;
    e = '0;
    e[FRAME_LSB +: FRAME_W] = frame;
    e[BIT_P] = 1'b1;
    e[BIT_RW] = 1'b1;
    return e;
  endfunction

endpackage

// ===== hw/rtl/ptmw_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface ptmw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ptmw_pkg::VPAGE_W-1:0] virt_page;
  logic [ptmw_pkg::FRAME_W-1:0] phys_frame;

  modport source (output valid, output mode, output virt_page, output phys_frame,
                  input ready);
  modport sink (input valid, input mode, input virt_page, input phys_frame,
                output ready);
endinterface

interface ptmw_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptmw_pkg::STATUS_W-1:0] status;
  logic [ptmw_pkg::FRAME_W-1:0]  frame;
  logic [ptmw_pkg::ADDED_W-1:0]  tables_added;

  modport source (output valid, output status, output frame, output tables_added,
                  input ready);
  modport sink (input valid, input status, input frame, input tables_added,
                output ready);
endinterface

// ===== hw/rtl/ptmw_cfg.sv =====
// APB-style configuration registers: table pool frame and data base frame.
`timescale 1ns / 1ps
module ptmw_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptmw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ptmw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ptmw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [ptmw_pkg::FRAME_W-1:0]    pool_frame,
  output logic [ptmw_pkg::FRAME_W-1:0]    base_frame
);

  logic [ptmw_pkg::FRAME_W-1:0] pool_frame_r;
  logic [ptmw_pkg::FRAME_W-1:0] base_frame_r;
  logic                         wr_en;
  logic                         reg_sel;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ptmw_pkg::CFG_IDX_BIT];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_frame_r <= '0;
      base_frame_r <= '0;
    end else if (wr_en) begin
      if (reg_sel == ptmw_pkg::REG_POOL_FRAME) begin
        pool_frame_r <= pwdata[ptmw_pkg::FRAME_W-1:0];
      end else begin
        base_frame_r <= pwdata[ptmw_pkg::FRAME_W-1:0];
      end
    end
  end

  // Read-back mux.
  always_comb begin
    if (reg_sel == ptmw_pkg::REG_POOL_FRAME) begin
      prdata = ptmw_pkg::CFG_DATA_W'(pool_frame_r);
    end else begin
      prdata = ptmw_pkg::CFG_DATA_W'(base_frame_r);
    end
  end

  assign pool_frame = pool_frame_r;
  assign base_frame = base_frame_r;

endmodule

// ===== hw/rtl/ptmw_ctrl.sv =====
// Walk controller: sequences clearing, table reads, allocations and writes.
`timescale 1ns / 1ps
module ptmw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ptmw_pkg::ptmw_stat_t  stat,
  output ptmw_pkg::ptmw_cmd_t   cmd
);

  ptmw_pkg::state_t state_r;
  ptmw_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == ptmw_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptmw_pkg::S_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ptmw_pkg::S_IDLE;
        end
      end
      ptmw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ptmw_pkg::S_RD;
        end
      end
      ptmw_pkg::S_RD: begin
        state_nxt = ptmw_pkg::S_CHK;
      end
      ptmw_pkg::S_CHK: begin
        if (!stat.at_leaf) begin
          if (stat.ent_zero) begin
            state_nxt = ptmw_pkg::S_PREP;
          end else if (stat.inside_large || !stat.follow_ok) begin
            state_nxt = ptmw_pkg::S_DONE;
          end else begin
            state_nxt = ptmw_pkg::S_RD;
          end
        end else if (!stat.ent_zero) begin
          state_nxt = ptmw_pkg::S_DONE;
        end else begin
          state_nxt = ptmw_pkg::S_PREP;
        end
      end
      ptmw_pkg::S_PREP: begin
        if (stat.has_k && stat.pool_full) begin
          state_nxt = ptmw_pkg::S_DONE;
        end else if (stat.need_auto && stat.data_full) begin
          state_nxt = ptmw_pkg::S_DONE;
        end else if (stat.has_k) begin
          state_nxt = ptmw_pkg::S_ALLOC;
        end else begin
          state_nxt = ptmw_pkg::S_LEAF;
        end
      end
      ptmw_pkg::S_ALLOC: begin
        state_nxt = ptmw_pkg::S_LINK;
      end
      ptmw_pkg::S_LINK: begin
        if (stat.link_more) begin
          state_nxt = ptmw_pkg::S_ALLOC;
        end else begin
          state_nxt = ptmw_pkg::S_LEAF;
        end
      end
      ptmw_pkg::S_LEAF: begin
        state_nxt = ptmw_pkg::S_DONE;
      end
      ptmw_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ptmw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptmw_pkg::S_CLEAR;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    cmd.res_code = ptmw_pkg::STAT_MAPPED;
    case (state_r)
      ptmw_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ptmw_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      ptmw_pkg::S_RD: begin
        cmd.rd = 1'b1;
      end
      ptmw_pkg::S_CHK: begin
        if (!stat.at_leaf) begin
          if (stat.ent_zero) begin
            cmd.mark_k = 1'b1;
          end else if (stat.inside_large) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ptmw_pkg::STAT_INSIDE_LARGE;
          end else if (!stat.follow_ok) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ptmw_pkg::STAT_POOL_FULL;
          end else begin
            cmd.descend = 1'b1;
          end
        end else if (!stat.ent_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ptmw_pkg::STAT_ALREADY;
        end
      end
      ptmw_pkg::S_PREP: begin
        if (stat.has_k && stat.pool_full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ptmw_pkg::STAT_POOL_FULL;
        end else if (stat.need_auto && stat.data_full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ptmw_pkg::STAT_DATA_FULL;
        end else begin
          cmd.prep = 1'b1;
        end
      end
      ptmw_pkg::S_ALLOC: begin
        cmd.alloc = 1'b1;
      end
      ptmw_pkg::S_LINK: begin
        cmd.link = 1'b1;
      end
      ptmw_pkg::S_LEAF: begin
        cmd.leaf_wr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ptmw_pkg::STAT_MAPPED;
      end
      ptmw_pkg::S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.clr_step = 1'b0;
      end
    endcase
  end

  // Output valid flag: set on load, cleared by a completed transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptmw_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/ptmw_dp.sv =====
// Walk datapath: table memory, page flags, allocation counters and results.
`timescale 1ns / 1ps
module ptmw_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptmw_pkg::ptmw_cmd_t                cmd,
  output ptmw_pkg::ptmw_stat_t               stat,
  input  logic [ptmw_pkg::FRAME_W-1:0]       pool_frame,
  input  logic [ptmw_pkg::FRAME_W-1:0]       base_frame,
  input  logic                               in_mode,
  input  logic [ptmw_pkg::VPAGE_W-1:0]       in_virt_page,
  input  logic [ptmw_pkg::FRAME_W-1:0]       in_phys_frame,
  output logic [ptmw_pkg::STATUS_W-1:0]      out_status,
  output logic [ptmw_pkg::FRAME_W-1:0]       out_frame,
  output logic [ptmw_pkg::ADDED_W-1:0]       out_tables_added
);

  // Table memory: each word carries an entry plus a page-clear tag bit.
  logic [ptmw_pkg::ENT_W:0]            mem [0:(1 << ptmw_pkg::ADDR_W)-1];
  logic [ptmw_pkg::ENT_W:0]            rdata_r;
  logic [ptmw_pkg::ADDR_W-1:0]         mem_addr;
  logic [ptmw_pkg::ENT_W:0]            mem_wdata;
  logic                                mem_we;

  // Control state.
  logic [ptmw_pkg::ADDR_W-1:0]         clr_r;
  logic [ptmw_pkg::POOL_PAGES-1:0]     pflag_r;
  logic [ptmw_pkg::CNT_W-1:0]          used_r;
  logic [ptmw_pkg::DCNT_W-1:0]         ndf_r;

  // Request registers.
  logic                                mode_r;
  logic [ptmw_pkg::VPAGE_W-1:0]        vp_r;
  logic [ptmw_pkg::FRAME_W-1:0]        pf_r;
  logic [ptmw_pkg::PAGE_W-1:0]         page_r;
  logic [1:0]                          lvl_r;
  logic [1:0]                          k_r;
  logic [ptmw_pkg::PAGE_W-1:0]         fresh_r;
  logic [ptmw_pkg::FRAME_W-1:0]        frame_r;
  logic                                auto_r;

  // Result and output registers.
  logic [ptmw_pkg::STATUS_W-1:0]       res_status_r;
  logic [ptmw_pkg::FRAME_W-1:0]        res_frame_r;
  logic [ptmw_pkg::ADDED_W-1:0]        res_k_r;
  logic [ptmw_pkg::STATUS_W-1:0]       out_status_r;
  logic [ptmw_pkg::FRAME_W-1:0]        out_frame_r;
  logic [ptmw_pkg::ADDED_W-1:0]        out_k_r;

  // Derived values.
  logic [1:0]                          leaf_lvl;
  logic [ptmw_pkg::IDX_W-1:0]          idx;
  logic [ptmw_pkg::ENT_W-1:0]          ent;
  logic [ptmw_pkg::FRAME_W-1:0]        ent_frame;
  logic [ptmw_pkg::FRAME_W-1:0]        follow_off;
  logic [ptmw_pkg::ENT_W-1:0]          leaf_ent;
  logic [ptmw_pkg::CNT_W:0]            used_sum;

  assign leaf_lvl = {1'b0, mode_r};

  // Table index for the current level.
  always_comb begin
    case (lvl_r)
      ptmw_pkg::LVL_1: idx = vp_r[0 +: ptmw_pkg::IDX_W];
      ptmw_pkg::LVL_2: idx = vp_r[ptmw_pkg::IDX_W +: ptmw_pkg::IDX_W];
      ptmw_pkg::LVL_3: idx = vp_r[2 * ptmw_pkg::IDX_W +: ptmw_pkg::IDX_W];
      default:         idx = vp_r[3 * ptmw_pkg::IDX_W +: ptmw_pkg::IDX_W];
    endcase
  end

  // An entry written before its page was last cleared reads as zero.
  assign ent = (rdata_r[ptmw_pkg::ENT_W] == pflag_r[page_r]) ?
               rdata_r[ptmw_pkg::ENT_W-1:0] : '0;
  assign ent_frame  = ent[ptmw_pkg::FRAME_LSB +: ptmw_pkg::FRAME_W];
  assign follow_off = ent_frame - pool_frame;
  assign used_sum   = {1'b0, used_r} + (ptmw_pkg::CNT_W + 1)'(k_r);

  assign leaf_ent = ptmw_pkg::make_entry(frame_r) |
                    (ptmw_pkg::ENT_W'(mode_r) << ptmw_pkg::BIT_PS);

  // Status toward the controller.
  always_comb begin
    stat.clr_last     = &clr_r;
    stat.at_leaf      = (lvl_r == leaf_lvl);
    stat.ent_zero     = (ent == '0);
    stat.inside_large = (lvl_r == ptmw_pkg::LVL_2) && ent[ptmw_pkg::BIT_PS];
    stat.follow_ok    = (follow_off < ptmw_pkg::FRAME_W'(ptmw_pkg::POOL_PAGES));
    stat.has_k        = (k_r != 2'd0);
    stat.pool_full    = (used_sum >= (ptmw_pkg::CNT_W + 1)'(ptmw_pkg::POOL_PAGES));
    stat.need_auto    = !mode_r && (pf_r == '0);
    stat.data_full    = (ndf_r >= ptmw_pkg::DCNT_W'(ptmw_pkg::DATA_PAGES));
    stat.link_more    = ((lvl_r - 2'd1) != leaf_lvl);
  end

  // Memory port address and write data.
  always_comb begin
    mem_we    = cmd.clr_step || cmd.link || cmd.leaf_wr;
    mem_addr  = {page_r, idx};
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_addr = clr_r;
    end else if (cmd.link) begin
      mem_wdata = {pflag_r[page_r],
                   ptmw_pkg::make_entry(pool_frame +
                                        ptmw_pkg::FRAME_W'(fresh_r))};
    end else if (cmd.leaf_wr) begin
      mem_wdata = {pflag_r[page_r], leaf_ent};
    end
  end

  // Single-port table memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (cmd.rd) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Clearing sweep, page flags and allocation counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      pflag_r <= '0;
      used_r  <= ptmw_pkg::CNT_W'(1);
      ndf_r   <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + ptmw_pkg::ADDR_W'(1);
      end
      if (cmd.alloc) begin
        pflag_r[used_r[ptmw_pkg::PAGE_W-1:0]] <= 1'b1;
        used_r <= used_r + ptmw_pkg::CNT_W'(1);
      end
      if (cmd.leaf_wr && auto_r) begin
        ndf_r <= ndf_r + ptmw_pkg::DCNT_W'(1);
      end
    end
  end

  // Request capture and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      vp_r   <= in_virt_page;
      pf_r   <= in_phys_frame;
      page_r <= '0;
      lvl_r  <= ptmw_pkg::LVL_4;
      k_r    <= 2'd0;
    end
    if (cmd.descend) begin
      page_r <= follow_off[ptmw_pkg::PAGE_W-1:0];
      lvl_r  <= lvl_r - 2'd1;
    end
    if (cmd.mark_k) begin
      k_r <= lvl_r - leaf_lvl;
    end
    if (cmd.prep) begin
      auto_r <= stat.need_auto;
      if (mode_r) begin
        frame_r <= {pf_r[ptmw_pkg::FRAME_W-1:ptmw_pkg::LARGE_W], {ptmw_pkg::LARGE_W{1'b0}}};
      end else if (pf_r == '0) begin
        frame_r <= base_frame + ptmw_pkg::FRAME_W'(ndf_r);
      end else begin
        frame_r <= pf_r;
      end
    end
    if (cmd.alloc) begin
      fresh_r <= used_r[ptmw_pkg::PAGE_W-1:0];
    end
    if (cmd.link) begin
      page_r <= fresh_r;
      lvl_r  <= lvl_r - 2'd1;
    end
  end

  // Result capture by status code.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_code;
      case (cmd.res_code)
        ptmw_pkg::STAT_MAPPED: begin
          res_frame_r <= frame_r;
          res_k_r     <= k_r;
        end
        ptmw_pkg::STAT_ALREADY, ptmw_pkg::STAT_INSIDE_LARGE: begin
          res_frame_r <= ent_frame;
          res_k_r     <= '0;
        end
        default: begin
          res_frame_r <= '0;
          res_k_r     <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_frame_r  <= res_frame_r;
      out_k_r      <= res_k_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_frame        = out_frame_r;
  assign out_tables_added = out_k_r;

endmodule

// ===== hw/rtl/page_table_map_walker.sv =====
// Top level of the four-level page table map walker.
`timescale 1ns / 1ps
// Installs one virtual-to-physical mapping per request into a four-level
// page table held in an internal pool of 128 table pages (root at page 0).
// Channels: in_ch carries mode, virt_page and phys_frame; out_ch returns
// status, frame and tables_added, one result per request. Both use
// valid/ready and a transfer happens when both are high at a clock edge.
// The cfg_ port is APB-style with 64-bit data: the table pool frame at
// address 0 and the data base frame at address 8; writes take effect in the
// access phase and registers should only change while the block is idle.
// After reset the table memory is swept to zero, one entry per cycle;
// in_ch.ready stays low during the sweep while the
// configuration port already works.
// One request is walked at a time. The single table-memory port does one
// read or one write per cycle. A result waits in an output register; the
// next request is accepted meanwhile, and its walk holds before the result
// stage until out_ch.ready frees that register.
module page_table_map_walker (
  input  logic                            clk,
  input  logic                            rst_n,
  ptmw_in_if.sink                         in_ch,
  ptmw_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ptmw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ptmw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ptmw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  ptmw_pkg::ptmw_cmd_t          cmd;
  ptmw_pkg::ptmw_stat_t         stat;
  logic [ptmw_pkg::FRAME_W-1:0] pool_frame;
  logic [ptmw_pkg::FRAME_W-1:0] base_frame;

  // Configuration registers.
  ptmw_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .pool_frame (pool_frame),
    .base_frame (base_frame)
  );

  // Walk controller.
  ptmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Walk datapath.
  ptmw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .pool_frame       (pool_frame),
    .base_frame       (base_frame),
    .in_mode          (in_ch.mode),
    .in_virt_page     (in_ch.virt_page),
    .in_phys_frame    (in_ch.phys_frame),
    .out_status       (out_ch.status),
    .out_frame        (out_ch.frame),
    .out_tables_added (out_ch.tables_added)
  );

  // Only a successful mapping reports newly added tables.
  a_added_only_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.tables_added != '0)) |->
      (out_ch.status == ptmw_pkg::STAT_MAPPED))
    else $error("tables added on a result that is not a fresh mapping");

  // A failing request reports no frame.
  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ptmw_pkg::STAT_POOL_FULL ||
                      out_ch.status == ptmw_pkg::STAT_DATA_FULL)) |->
      (out_ch.frame == '0))
    else $error("failure result carries a frame");

  // One request at a time: the input closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input stayed open after a request transfer");

endmodule
